// ===== sv/ctlm_pkg.sv =====
// Shared types, constants and saturation helper for the magnitude-indexed
// complex table interpolator. No dependencies.
`default_nettype none

package ctlm_pkg;

    // Default table size and the configuration port address width.
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int APB_ADDR_W      = 4;

    // Square root pipeline: two result bits per stage, 32 result bits.
    localparam int SQRT_STEPS  = 2;
    localparam int SQRT_STAGES = 32 / SQRT_STEPS;

    // Command codes carried in the cmd field.
    localparam logic CMD_EVAL  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Register word indexes (byte address bits [3:2]).
    localparam logic [1:0] REG_GRID_START    = 2'd0;
    localparam logic [1:0] REG_GRID_INV_STEP = 2'd1;
    localparam logic [1:0] REG_ENTRIES_USED  = 2'd2;

    // Register reset values.
    localparam logic [30:0] GRID_START_RST    = 31'd0;
    localparam logic [30:0] GRID_INV_STEP_RST = 31'd65536;
    localparam logic [10:0] ENTRIES_USED_RST  = 11'd1024;

    // Input beat.
    typedef struct packed {
        logic               cmd;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic [9:0]         entry_index;
        logic signed [31:0] entry_real;
        logic signed [31:0] entry_imag;
    } ctlm_in_t;

    // Result beat.
    typedef struct packed {
        logic signed [31:0] x_real;
        logic signed [31:0] x_imag;
        logic signed [31:0] y_real;
        logic signed [31:0] y_imag;
    } ctlm_out_t;

    // One complex table entry.
    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
    } coef_t;

    localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

    // Saturate a signed value to 32-bit signed.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX)
        begin
            r = 32'sh7fffffff;
        end
        else if (v < SAT_MIN)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/ctlm_sqrt.sv =====
// Pipelined integer square root of a 64-bit radicand, two root bits per stage.
// Depends on ctlm_pkg for the stage count.
`default_nettype none

module ctlm_sqrt (
    input  wire logic        clk,
    input  wire logic [63:0] radicand,
    output logic      [31:0] root
);

    typedef struct packed {
        logic [63:0] rad;
        logic [33:0] rem;
        logic [31:0] root;
    } sq_st_t;

    sq_st_t st_reg [ctlm_pkg::SQRT_STAGES];

    genvar k;
    generate
        for (k = 0; k < ctlm_pkg::SQRT_STAGES; k++)
        begin : g_stage
            sq_st_t      src;
            sq_st_t      cur;
            logic [35:0] remx;
            logic [35:0] trial;

            // The first stage starts from the radicand, later ones from the previous stage.
            if (k == 0)
            begin : g_first
                assign src = '{rad: radicand, rem: '0, root: '0};
            end
            else
            begin : g_next
                assign src = st_reg[k-1];
            end

            // Restoring square root steps on the remaining radicand bits.
            always_comb
            begin
                cur   = src;
                remx  = '0;
                trial = '0;
                for (int s = 0; s < ctlm_pkg::SQRT_STEPS; s++)
                begin
                    remx  = {cur.rem, cur.rad[63:62]};
                    trial = {2'b00, cur.root, 2'b01};
                    if (remx >= trial)
                    begin
                        cur.rem  = 34'(remx - trial);
                        cur.root = {cur.root[30:0], 1'b1};
                    end
                    else
                    begin
                        cur.rem  = remx[33:0];
                        cur.root = {cur.root[30:0], 1'b0};
                    end
                    cur.rad = {cur.rad[61:0], 2'b00};
                end
            end

            always_ff @(posedge clk)
            begin
                st_reg[k] <= cur;
            end
        end
    endgenerate

    assign root = st_reg[ctlm_pkg::SQRT_STAGES-1].root;

endmodule

`default_nettype wire

// ===== sv/ctlm_coef_mem.sv =====
// Complex coefficient table: one write port, two registered read ports.
// Depends on ctlm_pkg for the entry type.
`default_nettype none

module ctlm_coef_mem #(
    parameter int DEPTH = ctlm_pkg::TABLE_DEPTH_DEF,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  clk,
    input  wire logic                  we,
    input  wire logic [IDX_W-1:0]      waddr,
    input  wire ctlm_pkg::coef_t       wdata,
    input  wire logic [IDX_W-1:0]      raddr_lo,
    input  wire logic [IDX_W-1:0]      raddr_hi,
    output ctlm_pkg::coef_t            rd_lo,
    output ctlm_pkg::coef_t            rd_hi
);

    ctlm_pkg::coef_t mem [DEPTH];
    ctlm_pkg::coef_t rd_lo_reg;
    ctlm_pkg::coef_t rd_hi_reg;

    // Write and two reads; a read of the entry being written returns old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_lo_reg <= mem[raddr_lo];
        rd_hi_reg <= mem[raddr_hi];
    end

    assign rd_lo = rd_lo_reg;
    assign rd_hi = rd_hi_reg;

endmodule

`default_nettype wire

// ===== sv/ctlm_out_fifo.sv =====
// Result queue that decouples the pipeline from the receiver's stall.
// Depends on ctlm_pkg for the result beat type.
`default_nettype none

module ctlm_out_fifo #(
    parameter int DEPTH = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire ctlm_pkg::ctlm_out_t push_data,
    output logic                     valid,
    input  wire logic                stall,
    output ctlm_pkg::ctlm_out_t      data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ctlm_pkg::ctlm_out_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pop;

    assign valid = (cnt_reg != '0);
    assign pop   = valid && !stall;
    assign data  = mem_reg[rd_ptr_reg];

    // Pointer and count update; the caller never pushes into a full queue.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        cnt_next = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/complex_table_lerp_by_magnitude.sv =====
// Usage: the req channel takes one beat per cycle, unless req_stall is set.
// An evaluate beat (cmd 0) carries a vector; its length picks two neighboring
// entries of the complex table, which are interpolated (or extrapolated past
// the ends) and scaled by both components. A write beat (cmd 1) stores one
// table entry and gives no result; entries must be written before an evaluate
// reads them. The rsp channel returns one beat per evaluate beat, in order.
// Throughput is one beat per cycle while req_stall is low, as the 16-stage
// square root pipeline (two root bits per stage) and the two table reads per
// item, on separate ports, keep every stage busy. Table writes take effect in
// order with reads: an evaluate beat sees every write beat accepted before it.
// While the receiver stalls, results collect in a 29-entry queue; req_stall
// rises only when accepted evaluate beats not yet delivered fill it.
// Reset clears the pipeline, the queue and the registers (grid_start 0,
// grid_inv_step 1.0, entries_used 1024); the table contents are not cleared.
// Registers (APB, byte addresses 0, 4, 8) are to be written only while idle;
// the block itself does not enforce this.
// Depends on ctlm_pkg, ctlm_sqrt, ctlm_coef_mem and ctlm_out_fifo.
`default_nettype none

module complex_table_lerp_by_magnitude #(
    parameter int TABLE_DEPTH = ctlm_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              req_valid,
    output logic                                   req_stall,
    input  wire ctlm_pkg::ctlm_in_t                req_data,
    output logic                                   rsp_valid,
    input  wire logic                              rsp_stall,
    output ctlm_pkg::ctlm_out_t                    rsp_data,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [ctlm_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                       pwdata,
    output logic      [31:0]                       prdata,
    output logic                                   pready
);

    localparam int IDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int T_LEN      = 2 + ctlm_pkg::SQRT_STAGES;
    localparam int T_IF       = T_LEN + 3;
    localparam int T_C        = T_LEN + 6;
    localparam int T_M2       = T_LEN + 7;
    localparam int FIFO_DEPTH = T_M2 + 4;
    localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);

    // ---------------- configuration registers ----------------
    logic [30:0] grid_start_reg;
    logic [30:0] grid_inv_step_reg;
    logic [10:0] entries_used_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_start_reg    <= ctlm_pkg::GRID_START_RST;
            grid_inv_step_reg <= ctlm_pkg::GRID_INV_STEP_RST;
            entries_used_reg  <= ctlm_pkg::ENTRIES_USED_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                ctlm_pkg::REG_GRID_START:    grid_start_reg    <= pwdata[30:0];
                ctlm_pkg::REG_GRID_INV_STEP: grid_inv_step_reg <= pwdata[30:0];
                ctlm_pkg::REG_ENTRIES_USED:  entries_used_reg  <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (paddr[3:2])
            ctlm_pkg::REG_GRID_START:    prdata = {1'b0, grid_start_reg};
            ctlm_pkg::REG_GRID_INV_STEP: prdata = {1'b0, grid_inv_step_reg};
            ctlm_pkg::REG_ENTRIES_USED:  prdata = {21'd0, entries_used_reg};
            default:                     prdata = '0;
        endcase
    end

    // ---------------- input acceptance and credit ----------------
    logic             req_acc;
    logic             eval_acc;
    logic             rsp_take;
    logic [OCC_W-1:0] occ_reg, occ_next;

    assign req_stall = (occ_reg >= OCC_W'(FIFO_DEPTH));
    assign req_acc   = req_valid && !req_stall;
    assign eval_acc  = req_acc && (req_data.cmd == ctlm_pkg::CMD_EVAL);
    assign rsp_take  = rsp_valid && !rsp_stall;
    assign occ_next  = occ_reg + OCC_W'(eval_acc) - OCC_W'(rsp_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // ---------------- beat sideband delay line ----------------
    logic [T_M2:0]      vld_reg;
    ctlm_pkg::ctlm_in_t pl_reg [T_M2+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[T_M2-1:0], req_acc};
        end
    end

    always_ff @(posedge clk)
    begin
        pl_reg[0] <= req_data;
        for (int k = 1; k <= T_M2; k++)
        begin
            pl_reg[k] <= pl_reg[k-1];
        end
    end

    // ---------------- squared length ----------------
    logic signed [63:0] xx_reg, yy_reg;
    logic        [63:0] sq_reg;
    logic        [31:0] len;

    always_ff @(posedge clk)
    begin
        xx_reg <= pl_reg[0].vec_x * pl_reg[0].vec_x;
        yy_reg <= pl_reg[0].vec_y * pl_reg[0].vec_y;
        sq_reg <= unsigned'(xx_reg) + unsigned'(yy_reg);
    end

    ctlm_sqrt u_sqrt (
        .clk      (clk),
        .radicand (sq_reg),
        .root     (len)
    );

    // ---------------- grid position ----------------
    logic signed [32:0] diff_reg;
    logic signed [64:0] pos_full;
    logic signed [63:0] pos_reg;

    assign pos_full = diff_reg * $signed({1'b0, grid_inv_step_reg});

    always_ff @(posedge clk)
    begin
        diff_reg <= $signed({1'b0, len}) - $signed({2'b00, grid_start_reg});
        pos_reg  <= $signed(pos_full[63:0]);
    end

    // ---------------- index clamp and fraction ----------------
    logic signed [31:0] iraw;
    logic        [31:0] n_w;
    logic        [31:0] imax_w;
    logic        [31:0] i_w;
    logic signed [31:0] fhi;
    logic signed [47:0] f48;
    logic [IDX_W-1:0]   i_reg;
    logic signed [31:0] f_reg;
    logic signed [31:0] f_rd_reg;

    always_comb
    begin
        iraw = $signed(pos_reg[63:32]);
        if (32'(entries_used_reg) < 32'd2)
        begin
            n_w = 32'd2;
        end
        else if (32'(entries_used_reg) > 32'(TABLE_DEPTH))
        begin
            n_w = 32'(TABLE_DEPTH);
        end
        else
        begin
            n_w = 32'(entries_used_reg);
        end
        imax_w = n_w - 32'd2;
        if (iraw[31])
        begin
            i_w = '0;
        end
        else if (unsigned'(iraw) > imax_w)
        begin
            i_w = imax_w;
        end
        else
        begin
            i_w = unsigned'(iraw);
        end
        fhi = iraw - $signed(i_w);
        f48 = $signed({fhi, pos_reg[31:16]});
    end

    always_ff @(posedge clk)
    begin
        i_reg    <= IDX_W'(i_w);
        f_reg    <= ctlm_pkg::sat32(66'(f48));
        f_rd_reg <= f_reg;
    end

    // ---------------- table access ----------------
    logic            mem_we;
    ctlm_pkg::coef_t mem_wdata;
    ctlm_pkg::coef_t c_lo, c_hi;

    assign mem_we = vld_reg[T_IF] && (pl_reg[T_IF].cmd == ctlm_pkg::CMD_WRITE)
                    && (32'(pl_reg[T_IF].entry_index) < 32'(TABLE_DEPTH));
    assign mem_wdata = '{re: pl_reg[T_IF].entry_real, im: pl_reg[T_IF].entry_imag};

    ctlm_coef_mem #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk      (clk),
        .we       (mem_we),
        .waddr    (IDX_W'(pl_reg[T_IF].entry_index)),
        .wdata    (mem_wdata),
        .raddr_lo (i_reg),
        .raddr_hi (i_reg + IDX_W'(1)),
        .rd_lo    (c_lo),
        .rd_hi    (c_hi)
    );

    // ---------------- interpolation ----------------
    logic signed [32:0] omf;
    logic signed [63:0] pa_re_reg, pa_im_reg;
    logic signed [64:0] pb_re_reg, pb_im_reg;
    logic signed [49:0] sum_re, sum_im;
    logic signed [31:0] cr_reg, ci_reg;

    assign omf    = 33'sd65536 - 33'(f_rd_reg);
    assign sum_re = 50'(pa_re_reg >>> 16) + 50'(pb_re_reg >>> 16);
    assign sum_im = 50'(pa_im_reg >>> 16) + 50'(pb_im_reg >>> 16);

    always_ff @(posedge clk)
    begin
        pa_re_reg <= f_rd_reg * c_hi.re;
        pa_im_reg <= f_rd_reg * c_hi.im;
        pb_re_reg <= omf * c_lo.re;
        pb_im_reg <= omf * c_lo.im;
        cr_reg    <= ctlm_pkg::sat32(66'(sum_re));
        ci_reg    <= ctlm_pkg::sat32(66'(sum_im));
    end

    // ---------------- scaling by the vector ----------------
    logic signed [63:0] pxr_reg, pxi_reg, pyr_reg, pyi_reg;
    ctlm_pkg::ctlm_out_t res;
    logic                push;

    always_ff @(posedge clk)
    begin
        pxr_reg <= cr_reg * pl_reg[T_C].vec_x;
        pxi_reg <= ci_reg * pl_reg[T_C].vec_x;
        pyr_reg <= cr_reg * pl_reg[T_C].vec_y;
        pyi_reg <= ci_reg * pl_reg[T_C].vec_y;
    end

    assign res.x_real = ctlm_pkg::sat32(66'(pxr_reg >>> 16));
    assign res.x_imag = ctlm_pkg::sat32(66'(pxi_reg >>> 16));
    assign res.y_real = ctlm_pkg::sat32(66'(pyr_reg >>> 16));
    assign res.y_imag = ctlm_pkg::sat32(66'(pyi_reg >>> 16));
    assign push = vld_reg[T_M2] && (pl_reg[T_M2].cmd == ctlm_pkg::CMD_EVAL);

    ctlm_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res),
        .valid     (rsp_valid),
        .stall     (rsp_stall),
        .data      (rsp_data)
    );

endmodule

`default_nettype wire

// ===== sv/ctlm_check.sv =====
// Port-level checks for the table interpolator, bound to the top level.
// Depends on ctlm_pkg and complex_table_lerp_by_magnitude.
`default_nettype none

module ctlm_check (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            req_valid,
    input wire logic                            req_stall,
    input wire ctlm_pkg::ctlm_in_t              req_data,
    input wire logic                            rsp_valid,
    input wire logic                            rsp_stall,
    input wire ctlm_pkg::ctlm_out_t             rsp_data,
    input wire logic                            psel,
    input wire logic                            penable,
    input wire logic                            pwrite,
    input wire logic [ctlm_pkg::APB_ADDR_W-1:0] paddr,
    input wire logic [31:0]                     pwdata,
    input wire logic [31:0]                     prdata,
    input wire logic                            pready
);

    // A stalled result beat stays offered.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload.
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(rsp_data))
        else $error("result payload changed while stalled");

    // Leaving reset, the block is empty and ready.
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !rsp_valid && !req_stall)
        else $error("block not empty after reset");

    // A grid register reads back what was last written to it.
    a_grid_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready
         && (paddr[3:2] == ctlm_pkg::REG_GRID_START
             || paddr[3:2] == ctlm_pkg::REG_GRID_INV_STEP))
        ##1 (paddr == $past(paddr))
        |-> prdata == {1'b0, $past(pwdata[30:0])})
        else $error("grid register read-back mismatch");

endmodule

bind complex_table_lerp_by_magnitude ctlm_check u_ctlm_check (.*);

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for complex_table_lerp_by_magnitude: random and directed
// evaluate and table-write beats checked against an in-bench predictor.
// Depends on ctlm_pkg and the block's RTL.
module testbench;

    localparam int DEPTH      = 1024;
    localparam int DRAIN_WAIT = 40;
    localparam int STALL_MAX  = 20000;
    localparam int N_PHASES   = 5;
    localparam int PHASE_LEN  = 113;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    ctlm_pkg::ctlm_in_t req_data = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    ctlm_pkg::ctlm_out_t rsp_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ctlm_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    // Predictor copy of the registers and the table.
    longint grid_start_q;
    longint grid_step_q;
    longint entries_q;
    logic signed [31:0] tbl_re [DEPTH];
    logic signed [31:0] tbl_im [DEPTH];

    ctlm_pkg::ctlm_in_t  beats_to_send[$];
    ctlm_pkg::ctlm_out_t awaited_results[$];
    int error_count = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    complex_table_lerp_by_magnitude dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    // Saturate to the signed 32-bit range.
    function automatic longint clip32(input longint v);
        longint r;
        r = v;
        if (v > 64'sd2147483647)
        begin
            r = 64'sd2147483647;
        end
        else if (v < -64'sd2147483648)
        begin
            r = -64'sd2147483648;
        end
        return r;
    endfunction

    // Integer square root, one result bit per step.
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
        begin
            bitv = bitv >> 2;
        end
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Blend two neighboring entry parts with fraction f in Q16.16.
    function automatic longint blend(input longint lo, input longint hi, input longint f);
        longint a;
        longint b;
        a = (f * hi) >>> 16;
        b = ((64'sd65536 - f) * lo) >>> 16;
        return clip32(a + b);
    endfunction

    // Expected result beat for one evaluate vector.
    function automatic ctlm_pkg::ctlm_out_t lerp_scaled(input longint x, input longint y);
        longint unsigned sq;
        longint len;
        longint n;
        longint pos;
        longint idx;
        longint frac;
        longint cr;
        longint ci;
        ctlm_pkg::ctlm_out_t r;
        sq = longint'(x * x) + longint'(y * y);
        len = longint'(int_sqrt(sq));
        n = entries_q < 2 ? 2 : (entries_q > DEPTH ? DEPTH : entries_q);
        pos = (len - grid_start_q) * grid_step_q;
        idx = pos >>> 32;
        if (idx < 0)
        begin
            idx = 0;
        end
        else if (idx > n - 2)
        begin
            idx = n - 2;
        end
        frac = clip32((pos - (idx << 32)) >>> 16);
        cr = blend(longint'(tbl_re[idx]), longint'(tbl_re[idx + 1]), frac);
        ci = blend(longint'(tbl_im[idx]), longint'(tbl_im[idx + 1]), frac);
        r.x_real = 32'(clip32((cr * x) >>> 16));
        r.x_imag = 32'(clip32((ci * x) >>> 16));
        r.y_real = 32'(clip32((cr * y) >>> 16));
        r.y_imag = 32'(clip32((ci * y) >>> 16));
        return r;
    endfunction

    // Apply one accepted request beat to the predictor.
    task automatic absorb_beat(input ctlm_pkg::ctlm_in_t b);
        if (b.cmd == ctlm_pkg::CMD_WRITE)
        begin
            if (b.entry_index < DEPTH)
            begin
                tbl_re[b.entry_index] = b.entry_real;
                tbl_im[b.entry_index] = b.entry_imag;
            end
        end
        else
        begin
            awaited_results.push_back(lerp_scaled(longint'(b.vec_x), longint'(b.vec_y)));
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // Request driver: a new beat loads only when the current one is taken.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                absorb_beat(req_data);
            end
            if (!req_valid || !req_stall)
            begin
                if (beats_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req_valid <= 1'b1;
                    req_data <= beats_to_send.pop_front();
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stall.
    always @(posedge clk)
    begin
        ctlm_pkg::ctlm_out_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    report_mismatch("unexpected beat", rsp_data.x_real, 32'h0);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (rsp_data.x_real !== want.x_real)
                        report_mismatch("x_real", rsp_data.x_real, want.x_real);
                    if (rsp_data.x_imag !== want.x_imag)
                        report_mismatch("x_imag", rsp_data.x_imag, want.x_imag);
                    if (rsp_data.y_real !== want.y_real)
                        report_mismatch("y_real", rsp_data.y_real, want.y_real);
                    if (rsp_data.y_imag !== want.y_imag)
                        report_mismatch("y_imag", rsp_data.y_imag, want.y_imag);
                end
            end
            rsp_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_MAX)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic reg_write(input logic [1:0] reg_idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (reg_idx)
            ctlm_pkg::REG_GRID_START:    grid_start_q = value & 32'h7fffffff;
            ctlm_pkg::REG_GRID_INV_STEP: grid_step_q = value & 32'h7fffffff;
            ctlm_pkg::REG_ENTRIES_USED:  entries_q = value & 32'h7ff;
            default:                     ;
        endcase
    endtask

    // Wait until all sent beats are taken and every result has come back.
    task automatic drain_block();
        while (beats_to_send.size() != 0 || req_valid || awaited_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Random Q16.16 value: full range, small, or an extreme.
    function automatic logic [31:0] pick_value();
        int k;
        logic [31:0] v;
        k = $urandom_range(9);
        v = $urandom;
        if (k < 4)
        begin
            v = $urandom;
        end
        else if (k < 8)
        begin
            v = $signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
        end
        else if (k == 8)
        begin
            v = 32'h7fffffff;
        end
        else
        begin
            v = 32'h80000000;
        end
        return v;
    endfunction

    // Vector component sized to land mostly inside the current grid.
    function automatic logic [31:0] pick_component();
        int k;
        logic [31:0] v;
        k = $urandom_range(9);
        if (k < 6)
        begin
            v = $urandom_range(32'h0400_0000);
            if ($urandom_range(1))
                v = -v;
        end
        else if (k < 8)
        begin
            v = $urandom_range(32'h0004_0000);
            if ($urandom_range(1))
                v = -v;
        end
        else
        begin
            v = $urandom;
        end
        return v;
    endfunction

    function automatic ctlm_pkg::ctlm_in_t eval_beat(input logic [31:0] x,
                                                     input logic [31:0] y);
        ctlm_pkg::ctlm_in_t b;
        b = '0;
        b.cmd = ctlm_pkg::CMD_EVAL;
        b.vec_x = x;
        b.vec_y = y;
        b.entry_index = 10'($urandom);
        b.entry_real = $urandom;
        b.entry_imag = $urandom;
        return b;
    endfunction

    function automatic ctlm_pkg::ctlm_in_t write_beat(input logic [9:0] idx,
                                                      input logic [31:0] re,
                                                      input logic [31:0] im);
        ctlm_pkg::ctlm_in_t b;
        b.cmd = ctlm_pkg::CMD_WRITE;
        b.vec_x = $urandom;
        b.vec_y = $urandom;
        b.entry_index = idx;
        b.entry_real = re;
        b.entry_imag = im;
        return b;
    endfunction

    initial
    begin
        logic [31:0] gs_val;
        logic [31:0] step_val;
        logic [31:0] count_val;
        grid_start_q = ctlm_pkg::GRID_START_RST;
        grid_step_q = ctlm_pkg::GRID_INV_STEP_RST;
        entries_q = ctlm_pkg::ENTRIES_USED_RST;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Fill the whole table so that every later read hits a written entry.
        beats_to_send.push_back(write_beat(10'd0, 32'h7fffffff, 32'h80000000));
        beats_to_send.push_back(write_beat(10'd1, 32'h80000000, 32'h7fffffff));
        for (int i = 2; i < DEPTH - 1; i++)
        begin
            beats_to_send.push_back(write_beat(10'(i), pick_value(), pick_value()));
        end
        beats_to_send.push_back(write_beat(10'd1023, 32'h7fffffff, 32'h7fffffff));

        // Directed vectors: zero length, exact grid points, extremes, far beyond the end.
        beats_to_send.push_back(eval_beat(32'h0, 32'h0));
        beats_to_send.push_back(eval_beat(32'h0001_0000, 32'h0));
        beats_to_send.push_back(eval_beat(32'h0, 32'hffff_0000));
        beats_to_send.push_back(eval_beat(32'h0003_0000, 32'h0004_0000));
        beats_to_send.push_back(eval_beat(32'h0000_8000, 32'h0));
        beats_to_send.push_back(eval_beat(32'h7fffffff, 32'h0));
        beats_to_send.push_back(eval_beat(32'h80000000, 32'h80000000));
        beats_to_send.push_back(eval_beat(32'h7fffffff, 32'h7fffffff));
        beats_to_send.push_back(eval_beat(32'h03ff_0000, 32'h0));
        beats_to_send.push_back(eval_beat(32'h03fe_8000, 32'h0));
        beats_to_send.push_back(eval_beat(32'h0, 32'h0000_0001));
        beats_to_send.push_back(eval_beat(32'hffffffff, 32'h80000000));
        drain_block();

        // Phases with different grid settings and idling patterns.
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    gs_val = 32'd0;
                    step_val = 32'd65536;
                    count_val = 32'd1024;
                end
                1:
                begin
                    gs_val = 32'd0;
                    step_val = 32'h7fffffff;
                    count_val = 32'd2;
                end
                2:
                begin
                    gs_val = 32'h7fffffff;
                    step_val = 32'd0;
                    count_val = 32'd1;
                end
                3:
                begin
                    gs_val = $urandom_range(32'h0200_0000);
                    step_val = $urandom_range(32'h0008_0000);
                    count_val = 32'h7ff;
                end
                default:
                begin
                    gs_val = $urandom;
                    step_val = $urandom;
                    count_val = $urandom_range(1100);
                end
            endcase
            reg_write(ctlm_pkg::REG_GRID_START, gs_val);
            reg_write(ctlm_pkg::REG_GRID_INV_STEP, step_val);
            reg_write(ctlm_pkg::REG_ENTRIES_USED, count_val);
            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 64;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 64;
                end
                default:
                begin
                    send_idle_pct = 16;
                    stall_pct = 16;
                end
            endcase
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                if ($urandom_range(9) == 0)
                    beats_to_send.push_back(write_beat(10'($urandom), pick_value(),
                                                       pick_value()));
                else
                    beats_to_send.push_back(eval_beat(pick_component(), pick_component()));
            end
            drain_block();
        end

        if (error_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
sv/ctlm_pkg.sv
sv/ctlm_sqrt.sv
sv/ctlm_coef_mem.sv
sv/ctlm_out_fifo.sv
sv/complex_table_lerp_by_magnitude.sv
sv/ctlm_check.sv
dv/testbench.sv
